// ===== src/lms_pkg.sv =====
// shared types and constants for the led matrix scan controller
package lms_pkg;

  localparam int LINE_MAX_W   = 4;
  localparam int PIX_PER_BYTE = 8;
  localparam logic [7:0] SCAN_OFF = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_COPY  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } lms_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RECT,
    ST_SCAN
  } lms_state_t;

  typedef enum logic [1:0] {
    K_COPY,
    K_BLANK,
    K_STREAM
  } lms_kind_t;

  // one scan store read issued by the sequencer, retired once its read data is registered
  typedef struct packed {
    logic                  valid;
    lms_kind_t             kind;
    logic [2:0]            bit_idx;
    logic [2:0]            pix;
    logic                  last;
    logic [LINE_MAX_W-1:0] line;
  } lms_issue_t;

endpackage

// ===== src/lms_ram.sv =====
// generic single write port, single read port ram with registered read
module lms_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lms_seq.sv =====
// sequencer: clear pass, item decode, rectangle walk and scan line stream
module lms_seq #(
  parameter int WIDTH  = 64,
  parameter int MUX    = 16,
  parameter int HEIGHT = 128
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [1:0]                                  opcode,
  input  logic [5:0]                                  col,
  input  logic [6:0]                                  row,
  input  logic [5:0]                                  col_end,
  input  logic [6:0]                                  row_end,
  input  logic [2:0]                                  byte_col,
  input  logic [7:0]                                  pixel_byte,
  input  logic                                        scan_enable,
  output logic                                        busy,
  output logic                                        disp_we,
  output logic [$clog2(HEIGHT)+2:0]                   disp_waddr,
  output logic [7:0]                                  disp_wdata,
  output logic [$clog2(HEIGHT)+2:0]                   disp_raddr,
  output logic [$clog2(MUX)+$clog2(WIDTH)-1:0]        scan_raddr,
  output logic                                        clearing,
  output logic [$clog2(MUX)+$clog2(WIDTH)-1:0]        clr_waddr,
  output lms_pkg::lms_issue_t                         issue
);
  import lms_pkg::*;

  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int LINE_W = $clog2(MUX);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int DA_W   = ROW_W + 3;
  localparam int SA_W   = LINE_W + COL_W;
  localparam int CLR_W  = (DA_W > SA_W) ? DA_W : SA_W;
  localparam int BYTES  = (WIDTH + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
  localparam int YLIM   = (HEIGHT < PIX_PER_BYTE * MUX) ? HEIGHT : PIX_PER_BYTE * MUX;

  lms_state_t        state, state_next;
  logic [CLR_W-1:0]  clr_addr;
  logic              op_copy;
  logic [5:0]        x, x0, x1;
  logic [6:0]        y, y_end;
  logic [6:0]        rem;
  logic [2:0]        quot;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] line_counter;
  logic [COL_W-1:0]  k;

  logic accept;
  logic rect_ok;
  logic div_done;
  logic row_done;
  logic rect_done;
  logic scan_done;

  assign accept    = start && (state == ST_IDLE);
  assign rect_ok   = (col_end >= col) && (row_end >= row) &&
                     ({1'b0, col} < 7'(WIDTH)) && ({1'b0, row} < 8'(YLIM));
  assign div_done  = rem < 7'(MUX);
  assign row_done  = x == x1;
  assign rect_done = row_done && (y == y_end);
  assign scan_done = k == COL_W'(WIDTH - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (&clr_addr) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (lms_op_t'(opcode))
            OP_COPY, OP_CLEAR: if (rect_ok) state_next = ST_DIV;
            OP_TICK:           if (scan_enable) state_next = ST_SCAN;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_next = ST_RECT;
      ST_RECT: if (rect_done) state_next = ST_IDLE;
      ST_SCAN: if (scan_done) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    busy          = state != ST_IDLE;
    clearing      = state == ST_CLEAR;
    clr_waddr     = clr_addr[SA_W-1:0];
    disp_we       = 1'b0;
    disp_waddr    = {row[ROW_W-1:0], byte_col};
    disp_wdata    = pixel_byte;
    disp_raddr    = {y[ROW_W-1:0], x[5:3]};
    scan_raddr    = {line, x[COL_W-1:0]};
    issue         = '0;
    issue.kind    = K_COPY;
    case (state)
      ST_CLEAR: begin
        disp_we    = 1'b1;
        disp_waddr = clr_addr[DA_W-1:0];
        disp_wdata = 8'h00;
      end
      ST_IDLE: begin
        disp_we = accept && (lms_op_t'(opcode) == OP_WRITE) &&
                  ({1'b0, row} < 8'(HEIGHT)) && ({1'b0, byte_col} < 4'(BYTES));
      end
      ST_RECT: begin
        issue.valid   = 1'b1;
        issue.kind    = op_copy ? K_COPY : K_BLANK;
        issue.bit_idx = quot;
        issue.pix     = x[2:0];
      end
      ST_SCAN: begin
        scan_raddr  = {line_counter, k};
        issue.valid = 1'b1;
        issue.kind  = K_STREAM;
        issue.last  = scan_done;
        issue.line  = LINE_MAX_W'(line_counter);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      line_counter <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_SCAN: begin
          if (scan_done) begin
            line_counter <= (line_counter == LINE_W'(MUX - 1)) ? '0 : line_counter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // walk registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_copy <= lms_op_t'(opcode) == OP_COPY;
        x0      <= col;
        x       <= col;
        x1      <= ({1'b0, col_end} > 7'(WIDTH - 1)) ? 6'(WIDTH - 1) : col_end;
        y       <= row;
        y_end   <= ({1'b0, row_end} > 8'(YLIM - 1)) ? 7'(YLIM - 1) : row_end;
        rem     <= row;
        quot    <= '0;
        k       <= '0;
      end
      ST_DIV: begin
        // row split into scan line and bit plane by repeated subtraction
        if (div_done) begin
          line <= rem[LINE_W-1:0];
        end else begin
          rem  <= rem - 7'(MUX);
          quot <= quot + 1'b1;
        end
      end
      ST_RECT: begin
        if (row_done) begin
          x <= x0;
          y <= y + 1'b1;
          if (line == LINE_W'(MUX - 1)) begin
            line <= '0;
            quot <= quot + 1'b1;
          end else begin
            line <= line + 1'b1;
          end
        end else begin
          x <= x + 1'b1;
        end
      end
      ST_SCAN: k <= k + 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/led_matrix_scan_controller.sv =====
// top level of the led matrix scan controller: stores, write-back and result port
// A start transfer is taken when start is high and busy is low. A byte write
// (opcode 0) finishes in the cycle it is taken and never raises busy. A
// rectangle copy or clear first splits the start row into scan line and bit
// plane by repeated subtraction of MUX, then walks the clipped rectangle,
// one read-modify-write of the scan store per pixel. A refresh tick with
// scanning enabled makes one scan store read per cycle, and the WIDTH result
// transfers follow at that rate, each marked by strobe for exactly one cycle;
// the receiver cannot hold them off. After reset both stores are swept in
// full, one entry per cycle; busy stays high during that pass, while cfg_we
// writes to scan_enable are taken at any time.
module led_matrix_scan_controller #(
  parameter int WIDTH  = 64,
  parameter int MUX    = 16,
  parameter int HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [5:0] col,
  input  logic [6:0] row,
  input  logic [5:0] col_end,
  input  logic [6:0] row_end,
  input  logic [2:0] byte_col,
  input  logic [7:0] pixel_byte,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       strobe,
  output logic [7:0] scan_byte,
  output logic [3:0] row_address,
  output logic       last
);
  import lms_pkg::*;

  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int LINE_W = $clog2(MUX);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int DA_W   = ROW_W + 3;
  localparam int SA_W   = LINE_W + COL_W;

  // configuration register
  logic scan_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable <= 1'b0;
    end else if (cfg_we) begin
      scan_enable <= cfg_wdata;
    end
  end

  // sequencer
  logic             disp_we;
  logic [DA_W-1:0]  disp_waddr;
  logic [7:0]       disp_wdata;
  logic [DA_W-1:0]  disp_raddr;
  logic [7:0]       disp_rdata;
  logic [SA_W-1:0]  scan_raddr;
  logic [7:0]       scan_rdata;
  logic             clearing;
  logic [SA_W-1:0]  clr_waddr;
  lms_issue_t       issue;

  lms_seq #(
    .WIDTH  (WIDTH),
    .MUX    (MUX),
    .HEIGHT (HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .col         (col),
    .row         (row),
    .col_end     (col_end),
    .row_end     (row_end),
    .byte_col    (byte_col),
    .pixel_byte  (pixel_byte),
    .scan_enable (scan_enable),
    .busy        (busy),
    .disp_we     (disp_we),
    .disp_waddr  (disp_waddr),
    .disp_wdata  (disp_wdata),
    .disp_raddr  (disp_raddr),
    .scan_raddr  (scan_raddr),
    .clearing    (clearing),
    .clr_waddr   (clr_waddr),
    .issue       (issue)
  );

  // display store: eight bytes per panel row, 1 = lit
  lms_ram #(
    .DATA_W (8),
    .DEPTH  (2 ** DA_W)
  ) u_disp_ram (
    .clk   (clk),
    .we    (disp_we),
    .waddr (disp_waddr),
    .wdata (disp_wdata),
    .raddr (disp_raddr),
    .rdata (disp_rdata)
  );

  // scan store: one byte per scan line and column, 0 = led on
  logic             scan_we;
  logic [SA_W-1:0]  scan_waddr;
  logic [7:0]       scan_wdata;

  lms_ram #(
    .DATA_W (8),
    .DEPTH  (2 ** SA_W)
  ) u_scan_ram (
    .clk   (clk),
    .we    (scan_we),
    .waddr (scan_waddr),
    .wdata (scan_wdata),
    .raddr (scan_raddr),
    .rdata (scan_rdata)
  );

  // issue stage lines up with the registered read data
  lms_issue_t      issue_q;
  logic [SA_W-1:0] rmw_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q <= '0;
    end else begin
      issue_q <= issue;
    end
  end

  // write-back address, payload only
  always_ff @(posedge clk) begin
    rmw_addr <= scan_raddr;
  end

  // modify: copy inverts the display pixel, blank forces the bit to off
  logic       pix_off;
  logic [7:0] bit_mask;
  logic [7:0] merged;

  always_comb begin
    pix_off  = (issue_q.kind == K_BLANK) || !disp_rdata[issue_q.pix];
    bit_mask = 8'h01 << issue_q.bit_idx;
    merged   = pix_off ? (scan_rdata | bit_mask) : (scan_rdata & ~bit_mask);
  end

  // scan store write: clear pass first, otherwise rectangle write-back
  always_comb begin
    if (clearing) begin
      scan_we    = 1'b1;
      scan_waddr = clr_waddr;
      scan_wdata = SCAN_OFF;
    end else begin
      scan_we    = issue_q.valid && (issue_q.kind != K_STREAM);
      scan_waddr = rmw_addr;
      scan_wdata = merged;
    end
  end

  // result transfer straight from the scan store read register
  assign strobe      = issue_q.valid && (issue_q.kind == K_STREAM);
  assign scan_byte   = scan_rdata;
  assign last        = strobe && issue_q.last;
  assign row_address = last ? issue_q.line : 4'd0;

  // a rectangle read never hits the entry being written back
  assert property (@(posedge clk) disable iff (rst)
    (issue.valid && issue.kind != K_STREAM && scan_we && !clearing) |->
      (scan_raddr != scan_waddr))
    else $error("scan store read and write-back collide");

  // results only come out of work that kept busy high before them
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result transfer without a tick in progress");

  // a scan line ends with its last byte, no transfer comes straight after it
  assert property (@(posedge clk) disable iff (rst)
    last |=> !strobe)
    else $error("result transfer after end of scan line");

  // no result transfers while clearing, and busy stays high during the sweep
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!strobe && busy))
    else $error("activity during clear pass");

endmodule

// ===== bench/led_matrix_scan_controller_tb.sv =====
// self-checking testbench for the led matrix scan controller
module led_matrix_scan_controller_tb;
  import lms_pkg::*;

  // panel geometry of the instance under test (module defaults)
  localparam int WIDTH         = 64;
  localparam int MUX           = 16;
  localparam int HEIGHT        = 128;
  localparam int BYTES_PER_ROW = 8;
  localparam int BIT_PLANES    = 8;
  // cycles without any transfer before the run is declared hung; the slowest
  // legal command is a full panel rectangle
  localparam int IDLE_LIMIT    = 50000;

  // one command as it appears on the start port
  typedef struct packed {
    lms_op_t    op;
    logic [5:0] col;
    logic [6:0] row;
    logic [5:0] col_end;
    logic [6:0] row_end;
    logic [2:0] byte_col;
    logic [7:0] pixel_byte;
  } panel_cmd_t;

  // one streamed scan byte as it appears on the result port
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] addr;
    logic       last;
  } scan_beat_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] opcode;
  logic [5:0] col;
  logic [6:0] row;
  logic [5:0] col_end;
  logic [6:0] row_end;
  logic [2:0] byte_col;
  logic [7:0] pixel_byte;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       strobe;
  logic [7:0] scan_byte;
  logic [3:0] row_address;
  logic       last;

  // shadow copy of the panel: pixel store, scan store, line pointer, enable
  logic [7:0] pixel_mem [0:HEIGHT*BYTES_PER_ROW-1];
  logic [7:0] scan_mem  [0:MUX*WIDTH-1];
  int         next_line;
  logic       scan_en;

  // scan bytes predicted but not yet seen on the result port
  scan_beat_t expected_scan_q [$];
  scan_beat_t seen_beat;

  // run statistics
  int mismatches;
  int cmds_sent;
  int cmds_effective;
  int ticks_ignored;
  int lines_checked;
  int bytes_checked;
  int cfg_writes;
  int idle_cycles;
  bit gaps_on;

  led_matrix_scan_controller i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .col        (col),
    .row        (row),
    .col_end    (col_end),
    .row_end    (row_end),
    .byte_col   (byte_col),
    .pixel_byte (pixel_byte),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .strobe     (strobe),
    .scan_byte  (scan_byte),
    .row_address(row_address),
    .last       (last)
  );

  // 12 unit clock, rising edge at 6 + 12n
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // mismatch reporting: every failure is counted and printed
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // panel model
  // ---------------------------------------------------------------------------
  function automatic void reset_panel_model();
    foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
    foreach (scan_mem[i]) scan_mem[i] = SCAN_OFF;
    next_line = 0;
    scan_en   = 1'b0;
  endfunction

  // apply one accepted command to the shadow panel and queue the scan bytes
  // it streams out
  function automatic void update_panel_model(input panel_cmd_t c);
    int         x;
    int         y;
    int         k;
    int         plane;
    int         idx;
    logic       lit;
    scan_beat_t b;
    case (c.op)
      OP_WRITE: begin
        // out-of-panel byte writes are dropped
        if (c.row < HEIGHT && PIX_PER_BYTE * c.byte_col < WIDTH)
          pixel_mem[c.row * BYTES_PER_ROW + c.byte_col] = c.pixel_byte;
        cmds_effective++;
      end
      OP_COPY, OP_CLEAR: begin
        // an inverted rectangle (end before start) leaves everything alone
        if (c.col_end >= c.col && c.row_end >= c.row) begin
          for (y = c.row; y <= c.row_end && y < HEIGHT; y++) begin
            plane = y / MUX;
            if (plane < BIT_PLANES) begin
              for (x = c.col; x <= c.col_end && x < WIDTH; x++) begin
                lit = 1'b0;
                if (c.op == OP_COPY)
                  lit = pixel_mem[y * BYTES_PER_ROW + x / PIX_PER_BYTE][x % PIX_PER_BYTE];
                idx = (y % MUX) * WIDTH + x;
                // scan polarity is inverted: a 0 bit lights the led
                scan_mem[idx][plane] = ~lit;
              end
            end
          end
        end
        cmds_effective++;
      end
      OP_TICK: begin
        if (scan_en) begin
          for (k = 0; k < WIDTH; k++) begin
            b.data = scan_mem[next_line * WIDTH + k];
            b.last = (k == WIDTH - 1);
            b.addr = b.last ? 4'(next_line) : 4'd0;
            expected_scan_q.push_back(b);
          end
          next_line = (next_line + 1) % MUX;
          cmds_effective++;
        end else begin
          // a tick with scanning off is swallowed
          ticks_ignored++;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobe cycle is one transfer that must match the
  // oldest prediction field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) begin
      if (expected_scan_q.size() == 0) begin
        flag_mismatch($sformatf("scan byte %02h with nothing expected", scan_byte));
      end else begin
        seen_beat = expected_scan_q.pop_front();
        if (scan_byte !== seen_beat.data)
          flag_mismatch($sformatf("scan_byte %02h, expected %02h (byte %0d of line)",
                                  scan_byte, seen_beat.data, bytes_checked % WIDTH));
        if (last !== seen_beat.last)
          flag_mismatch($sformatf("last %b, expected %b", last, seen_beat.last));
        if (row_address !== seen_beat.addr)
          flag_mismatch($sformatf("row_address %0d, expected %0d",
                                  row_address, seen_beat.addr));
        bytes_checked++;
        if (seen_beat.last)
          lines_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles in which neither a start nor a result transfer
  // happens; covers the clearing sweep after reset and the largest rectangles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((!rst && start && !busy) || strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles, %0d scan bytes still pending",
               IDLE_LIMIT, expected_scan_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // command driver; entered and left at a falling edge so that back-to-back
  // commands keep start high without a gap
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input panel_cmd_t c);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap   = $urandom_range(1, 16);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    opcode     = c.op;
    col        = c.col;
    row        = c.row;
    col_end    = c.col_end;
    row_end    = c.row_end;
    byte_col   = c.byte_col;
    pixel_byte = c.pixel_byte;
    // transfer happens at the first rising edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    update_panel_model(c);
    cmds_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // wait until the block has drained: all scan bytes seen, busy low, and a
  // short margin for a rectangle that produces nothing
  task automatic wait_drained();
    start = 1'b0;
    while (expected_scan_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // scan_enable is only written while the block is quiet
  task automatic write_scan_enable(input logic value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = 1'($urandom_range(0, 1));
    scan_en   = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // command builders; fields a command does not use carry random values
  // ---------------------------------------------------------------------------
  function automatic panel_cmd_t random_fields();
    panel_cmd_t c;
    c.op         = OP_WRITE;
    c.col        = 6'($urandom_range(0, 63));
    c.row        = 7'($urandom_range(0, 127));
    c.col_end    = 6'($urandom_range(0, 63));
    c.row_end    = 7'($urandom_range(0, 127));
    c.byte_col   = 3'($urandom_range(0, 7));
    c.pixel_byte = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic panel_cmd_t byte_write(input int r, input int bc, input int px);
    panel_cmd_t c;
    c            = random_fields();
    c.op         = OP_WRITE;
    c.row        = 7'(r);
    c.byte_col   = 3'(bc);
    c.pixel_byte = 8'(px);
    return c;
  endfunction

  function automatic panel_cmd_t rect_cmd(input lms_op_t op, input int c0, input int r0,
                                          input int c1, input int r1);
    panel_cmd_t c;
    c         = random_fields();
    c.op      = op;
    c.col     = 6'(c0);
    c.row     = 7'(r0);
    c.col_end = 6'(c1);
    c.row_end = 7'(r1);
    return c;
  endfunction

  function automatic panel_cmd_t tick_cmd();
    panel_cmd_t c;
    c    = random_fields();
    c.op = OP_TICK;
    return c;
  endfunction

  // rectangle of random shape: mostly a few pixels, sometimes raw fields
  // (often inverted), now and then a big one
  function automatic panel_cmd_t random_rect(input lms_op_t op);
    panel_cmd_t c;
    int         a;
    int         b;
    c    = random_fields();
    c.op = op;
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        a         = $urandom_range(0, 63);
        b         = $urandom_range(0, 63);
        c.col     = 6'((a < b) ? a : b);
        c.col_end = 6'((a < b) ? b : a);
        a         = $urandom_range(0, 127);
        b         = $urandom_range(0, 127);
        c.row     = 7'((a < b) ? a : b);
        c.row_end = 7'((a < b) ? b : a);
      end
      default: begin
        a         = c.col + $urandom_range(0, 7);
        c.col_end = 6'((a > 63) ? 63 : a);
        a         = c.row + $urandom_range(0, 7);
        c.row_end = 7'((a > 127) ? 127 : a);
      end
    endcase
    return c;
  endfunction

  // a small drawing: write a few rows of one byte column, copy them into
  // the scan store, then show a line
  task automatic draw_and_show();
    int r;
    int bc;
    int n;
    int i;
    n  = $urandom_range(1, 4);
    r  = $urandom_range(0, 128 - n);
    bc = $urandom_range(0, 7);
    for (i = 0; i < n; i++)
      send_cmd(byte_write(r + i, bc, $urandom_range(0, 255)));
    send_cmd(rect_cmd(OP_COPY, bc * PIX_PER_BYTE + $urandom_range(0, 3), r,
                      bc * PIX_PER_BYTE + 4 + $urandom_range(0, 3), r + n - 1));
    send_cmd(tick_cmd());
  endtask

  // one random unit of traffic
  task automatic random_unit();
    case ($urandom_range(0, 9))
      0, 1, 2: draw_and_show();
      3, 4:    send_cmd(byte_write($urandom_range(0, 127), $urandom_range(0, 7),
                                   $urandom_range(0, 255)));
      5:       send_cmd(random_rect(OP_CLEAR));
      6:       send_cmd(random_rect(OP_COPY));
      default: send_cmd(tick_cmd());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // scanning is off after reset: a tick must produce nothing
  task automatic test_disabled_tick();
    send_cmd(tick_cmd());
  endtask

  // first lines after reset come out all dark, lines 0 and 1
  task automatic test_reset_lines();
    write_scan_enable(1'b1);
    send_cmd(tick_cmd());
    send_cmd(tick_cmd());
  endtask

  // byte writes at three corners of the pixel store and a few patterns
  task automatic test_byte_writes();
    send_cmd(byte_write(0, 0, 8'hFF));
    send_cmd(byte_write(2, 0, 8'h01));
    send_cmd(byte_write(66, 7, 8'h80));
    send_cmd(byte_write(127, 7, 8'hFF));
    send_cmd(byte_write(127, 0, 8'h00));
    send_cmd(byte_write(19, 3, 8'hA5));
  endtask

  // full-panel copy, empty rectangles both ways, single pixels, then show
  // lines 2 and 3 where rows 2, 19 and 66 land
  task automatic test_rectangles();
    send_cmd(rect_cmd(OP_COPY, 0, 0, 63, 127));
    send_cmd(rect_cmd(OP_CLEAR, 10, 2, 5, 2));
    send_cmd(rect_cmd(OP_CLEAR, 0, 66, 63, 65));
    send_cmd(rect_cmd(OP_COPY, 20, 0, 19, 127));
    send_cmd(rect_cmd(OP_CLEAR, 0, 2, 0, 2));
    send_cmd(rect_cmd(OP_CLEAR, 63, 127, 63, 127));
    send_cmd(rect_cmd(OP_COPY, 63, 127, 63, 127));
    send_cmd(tick_cmd());
    send_cmd(tick_cmd());
  endtask

  // random traffic with scanning on and sender gaps switching on and off
  task automatic test_streaming_mix(input int n);
    int base;
    write_scan_enable(1'b1);
    base = cmds_effective;
    while (cmds_effective - base < n) begin
      if ($urandom_range(0, 7) == 0)
        gaps_on = !gaps_on;
      random_unit();
    end
  endtask

  // random traffic with scanning off: ticks are swallowed, stores still move
  task automatic test_scan_disabled_mix(input int n);
    int base;
    write_scan_enable(1'b0);
    gaps_on = 1'b1;
    base    = cmds_effective;
    while (cmds_effective - base < n)
      random_unit();
  endtask

  // closing stretch: scanning on again, commands back to back
  task automatic test_back_to_back(input int n);
    int base;
    write_scan_enable(1'b1);
    gaps_on = 1'b0;
    base    = cmds_effective;
    while (cmds_effective - base < n)
      random_unit();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    opcode         = OP_WRITE;
    col            = '0;
    row            = '0;
    col_end        = '0;
    row_end        = '0;
    byte_col       = '0;
    pixel_byte     = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    gaps_on        = 1'b0;
    mismatches     = 0;
    cmds_sent      = 0;
    cmds_effective = 0;
    ticks_ignored  = 0;
    lines_checked  = 0;
    bytes_checked  = 0;
    cfg_writes     = 0;
    idle_cycles    = 0;
    reset_panel_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_disabled_tick();
    test_reset_lines();
    test_byte_writes();
    test_rectangles();
    test_streaming_mix(90);
    test_scan_disabled_mix(30);
    test_streaming_mix(40);
    test_back_to_back(40);

    // drain, then keep the clock running so that stray output shows
    wait_drained();
    repeat (WIDTH + 8) @(negedge clk);
    if (expected_scan_q.size() != 0)
      flag_mismatch($sformatf("%0d scan bytes never arrived", expected_scan_q.size()));

    $display("run: %0d commands sent (%0d ticks ignored while scanning was off)",
             cmds_sent, ticks_ignored);
    $display("run: %0d scan_enable writes, %0d scan lines and %0d scan bytes compared",
             cfg_writes, lines_checked, bytes_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lms_pkg.sv
src/lms_ram.sv
src/lms_seq.sv
src/led_matrix_scan_controller.sv
bench/led_matrix_scan_controller_tb.sv
